FILE: rtl/core/fifo_write_back_cache_defines.svh
// Assertion macros for the write-back cache checker.
`ifndef FIFO_WRITE_BACK_CACHE_DEFINES_SVH
`define FIFO_WRITE_BACK_CACHE_DEFINES_SVH
// Assert that a condition implies another in the same cycle.
`define FWBC_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("fwbc check failed");
// Assert that a condition implies another in the next cycle.
`define FWBC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("fwbc check failed");
`endif

FILE: rtl/core/fwbc_pkg.sv
package fwbc_pkg;
  typedef enum logic [1:0] {
    REQ_GET  = 2'd0,
    REQ_SET  = 2'd1,
    REQ_FILL = 2'd2,
    REQ_FLUSH = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    RESP_READ     = 3'd0,
    RESP_BREAD    = 3'd1,
    RESP_BWRITE   = 3'd2,
    RESP_NOTFOUND = 3'd3,
    RESP_DONE     = 3'd4
  } resp_kind_t;
endpackage

FILE: rtl/core/fifo_write_back_cache.sv
// A lookup reads the occupied slots one by one from the oldest, as does a flush.
// Throughput: one item at a time; busy stays high until its last result is out.
// The slot memory has one registered read port, which sets the scan rate.
// Reset: synchronous, active high; empties the cache and sets capacity to 16.
// The receiver cannot stall: each result is shown for one cycle with resp_valid.
module fifo_write_back_cache #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] req_key,
  input  logic [63:0] req_value,
  input  logic        fill_found,
  output logic        resp_valid,
  output logic [2:0]  resp_kind,
  output logic [63:0] resp_key,
  output logic [63:0] resp_value,
  output logic        resp_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fwbc_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 1 + KEY_BITS + VALUE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_EVRD, ST_EVCHK, ST_WR, ST_FRD, ST_FCHK
  } state_t;

  // Slot memory: {dirty, key, value}
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;
  logic [IW-1:0] raddr;
  logic          mem_we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  state_t          state;
  logic [4:0]      cap_reg;
  logic [IW-1:0]   oldest;
  logic [IW-1:0]   tail;
  logic [CW-1:0]   count;
  logic [CW-1:0]   scan_i;
  logic [IW-1:0]   scan_slot;
  logic [1:0]      op;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic            hit_q;
  logic [IW-1:0]   hit_slot;

  // Effective capacity: 0 acts as 1, above DEPTH acts as DEPTH
  logic [CW-1:0] cap;
  always_comb begin
    if (cap_reg == 5'd0) begin
      cap = CW'(1);
    end else if (32'(cap_reg) > 32'(DEPTH)) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(cap_reg);
    end
  end

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] s, input logic [CW-1:0] c);
    logic [CW:0] t;
    t = (CW+1)'(s) + (CW+1)'(1);
    if (t >= (CW+1)'(c)) begin
      wrap_inc = '0;
    end else begin
      wrap_inc = IW'(t);
    end
  endfunction

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  rd_dirty;
  assign rd_val   = rdata[VALUE_BITS-1:0];
  assign rd_key   = rdata[VALUE_BITS +: KEY_BITS];
  assign rd_dirty = rdata[EW-1];

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);
  assign pready = 1'b1;
  assign prdata = {27'd0, cap_reg};
  assign busy   = (state != ST_IDLE);

  logic full;
  assign full = (count >= cap);

  // Read address: scan slot, or oldest for eviction
  always_comb begin
    raddr = scan_slot;
    if (state == ST_CMP && !(rd_key == key_q) && !(scan_i + CW'(1) < count)) begin
      raddr = oldest;
    end else if (state == ST_EVRD) begin
      raddr = oldest;
    end
  end

  // Memory writes for set hits and inserts are issued from ST_WR
  always_comb begin
    mem_we = 1'b0;
    waddr  = tail;
    wdata  = {1'b1, key_q, val_q};
    if (state == ST_WR) begin
      mem_we = 1'b1;
      if (hit_q) begin
        waddr = hit_slot;
      end
      wdata = {op == REQ_SET, key_q, val_q};
    end
  end

  function automatic logic [63:0] kext(input logic [KEY_BITS-1:0] k);
    kext = 64'(k);
  endfunction
  function automatic logic [63:0] vext(input logic [VALUE_BITS-1:0] v);
    vext = 64'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cap_reg    <= 5'd16;
      oldest     <= '0;
      tail       <= '0;
      count      <= '0;
      resp_valid <= 1'b0;
      resp_last  <= 1'b0;
    end else begin
      resp_valid <= 1'b0;
      resp_last  <= 1'b0;
      if (cfg_wr) begin
        cap_reg <= pwdata[4:0];
        oldest  <= '0;
        tail    <= '0;
        count   <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            op        <= req_type;
            key_q     <= req_key[KEY_BITS-1:0];
            val_q     <= req_value[VALUE_BITS-1:0];
            hit_q     <= 1'b0;
            scan_i    <= '0;
            scan_slot <= oldest;
            if (req_type == REQ_FILL && !fill_found) begin
              resp_valid <= 1'b1;
              resp_last  <= 1'b1;
              resp_kind  <= RESP_NOTFOUND;
              resp_key   <= kext(req_key[KEY_BITS-1:0]);
              resp_value <= '0;
            end else if (count == '0) begin
              state <= (req_type == REQ_FLUSH) ? ST_FRD : ST_EVRD;
            end else begin
              state <= (req_type == REQ_FLUSH) ? ST_FRD : ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (rd_key == key_q) begin
            hit_q    <= 1'b1;
            hit_slot <= scan_slot;
            if (op == REQ_SET) begin
              state <= ST_WR;
            end else begin
              resp_valid <= 1'b1;
              resp_last  <= 1'b1;
              resp_kind  <= RESP_READ;
              resp_key   <= kext(key_q);
              resp_value <= vext(rd_val);
              state      <= ST_IDLE;
            end
          end else if (scan_i + CW'(1) < count) begin
            scan_i    <= scan_i + CW'(1);
            scan_slot <= wrap_inc(scan_slot, cap);
            state     <= ST_RD;
          end else if (op == REQ_GET) begin
            resp_valid <= 1'b1;
            resp_last  <= 1'b1;
            resp_kind  <= RESP_BREAD;
            resp_key   <= kext(key_q);
            resp_value <= '0;
            state      <= ST_IDLE;
          end else begin
            // oldest read issued this cycle
            state <= ST_EVCHK;
          end
        end
        ST_EVRD: begin
          if (op == REQ_GET) begin
            resp_valid <= 1'b1;
            resp_last  <= 1'b1;
            resp_kind  <= RESP_BREAD;
            resp_key   <= kext(key_q);
            resp_value <= '0;
            state      <= ST_IDLE;
          end else begin
            state <= ST_EVCHK;
          end
        end
        ST_EVCHK: begin
          // Evict the oldest entry when full, then write at the tail
          if (full) begin
            if (rd_dirty) begin
              resp_valid <= 1'b1;
              resp_kind  <= RESP_BWRITE;
              resp_key   <= kext(rd_key);
              resp_value <= vext(rd_val);
            end
          end
          state <= ST_WR;
        end
        ST_WR: begin
          resp_valid <= 1'b1;
          resp_last  <= 1'b1;
          if (op == REQ_SET) begin
            resp_kind  <= RESP_DONE;
            resp_value <= '0;
          end else begin
            resp_kind  <= RESP_READ;
            resp_value <= vext(val_q);
          end
          resp_key <= kext(key_q);
          if (!hit_q) begin
            if (full) begin
              oldest <= wrap_inc((32'(oldest) >= 32'(cap)) ? '0 : oldest, cap);
              count  <= cap;
            end else begin
              count <= count + CW'(1);
            end
            tail <= wrap_inc((32'(tail) >= 32'(cap)) ? '0 : tail, cap);
          end
          state <= ST_IDLE;
        end
        ST_FRD: begin
          if (scan_i < count) begin
            state <= ST_FCHK;
          end else begin
            resp_valid <= 1'b1;
            resp_last  <= 1'b1;
            resp_kind  <= RESP_DONE;
            resp_key   <= '0;
            resp_value <= '0;
            oldest     <= '0;
            tail       <= '0;
            count      <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_FCHK: begin
          if (rd_dirty) begin
            resp_valid <= 1'b1;
            resp_kind  <= RESP_BWRITE;
            resp_key   <= kext(rd_key);
            resp_value <= vext(rd_val);
          end
          scan_i    <= scan_i + CW'(1);
          scan_slot <= wrap_inc(scan_slot, cap);
          state     <= ST_FRD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/core/fwbc_checker.sv
`include "fifo_write_back_cache_defines.svh"
module fwbc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic resp_valid,
  input logic resp_last,
  input logic [2:0] resp_kind
);
  import fwbc_pkg::*;
  // Results only appear while an item is in flight or just after it closes
  `FWBC_ASSERT_IMPLY(a_last_has_valid, clk, rst, resp_last, resp_valid)
  `FWBC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy || resp_valid)
  `FWBC_ASSERT_IMPLY(a_wb_not_last, clk, rst, resp_valid && resp_kind == RESP_BWRITE,
    !resp_last)
  `FWBC_ASSERT_IMPLY(a_kind_range, clk, rst, resp_valid, resp_kind <= RESP_DONE)
endmodule

bind fifo_write_back_cache fwbc_checker u_fwbc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .resp_valid(resp_valid), .resp_last(resp_last), .resp_kind(resp_kind)
);

FILE: tb/tb_fifo_write_back_cache.sv
`timescale 1ns / 1ps

module tb_fifo_write_back_cache;
  import fwbc_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [1:0] ADDR_ACTIVE_CAPACITY = 2'd0;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    req_type_t   rtype;
    logic [63:0] key;
    logic [63:0] value;
    logic        found;
  } cache_req_t;

  typedef struct {
    resp_kind_t  kind;
    logic [63:0] key;
    logic [63:0] value;
    logic        last;
  } cache_resp_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [63:0] req_key;
  logic [63:0] req_value;
  logic        fill_found;
  logic        resp_valid;
  logic [2:0]  resp_kind;
  logic [63:0] resp_key;
  logic [63:0] resp_value;
  logic        resp_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fifo_write_back_cache i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .req_key(req_key), .req_value(req_value),
    .fill_found(fill_found), .resp_valid(resp_valid), .resp_kind(resp_kind),
    .resp_key(resp_key), .resp_value(resp_value), .resp_last(resp_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the cache contents
  logic [63:0] shadow_key [SLOTS];
  logic [63:0] shadow_val [SLOTS];
  bit          shadow_dirty [SLOTS];
  int unsigned shadow_oldest, shadow_next, shadow_count;
  logic [4:0]  shadow_capacity;

  cache_req_t  pending_reqs[$];
  cache_resp_t expected_resps[$];
  cache_req_t  cur_req;
  logic [63:0] key_pool [POOL_SIZE];
  bit          feed_hold;
  int          accepted_count;
  int          error_count;
  int          cycle_count;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int unsigned slots_in_use();
    if (shadow_capacity == 0) return 1;
    if (shadow_capacity > SLOTS) return SLOTS;
    return shadow_capacity;
  endfunction

  function automatic int lookup_slot(logic [63:0] key);
    int unsigned cap;
    int unsigned s;
    cap = slots_in_use();
    for (int unsigned i = 0; i < shadow_count && i < cap; i++) begin
      s = (shadow_oldest + i) % cap;
      if (shadow_key[s] == key) return s;
    end
    return -1;
  endfunction

  function automatic void push_resp(resp_kind_t kind, logic [63:0] key, logic [63:0] value);
    cache_resp_t r;
    r.kind = kind;
    r.key = key;
    r.value = value;
    r.last = 1'b0;
    expected_resps.push_back(r);
  endfunction

  // Insert at the tail, evicting the oldest entry when full
  function automatic void insert_entry(logic [63:0] key, logic [63:0] value, bit dirty);
    int unsigned cap;
    int unsigned h;
    cap = slots_in_use();
    if (shadow_count >= cap) begin
      h = shadow_oldest % cap;
      if (shadow_dirty[h]) push_resp(RESP_BWRITE, shadow_key[h], shadow_val[h]);
      shadow_oldest = (h + 1) % cap;
      shadow_count = cap;
    end else begin
      shadow_count++;
    end
    shadow_next = shadow_next % cap;
    shadow_key[shadow_next] = key;
    shadow_val[shadow_next] = value;
    shadow_dirty[shadow_next] = dirty;
    shadow_next = (shadow_next + 1) % cap;
  endfunction

  function automatic void empty_shadow();
    shadow_oldest = 0;
    shadow_next = 0;
    shadow_count = 0;
  endfunction

  // Compute the responses of one accepted request
  function automatic void predict_cache(cache_req_t rq);
    int s;
    int unsigned cap;
    int unsigned q;
    cache_resp_t r;
    case (rq.rtype)
      REQ_GET: begin
        s = lookup_slot(rq.key);
        if (s >= 0) push_resp(RESP_READ, rq.key, shadow_val[s]);
        else push_resp(RESP_BREAD, rq.key, 64'd0);
      end
      REQ_SET: begin
        s = lookup_slot(rq.key);
        if (s >= 0) begin
          shadow_val[s] = rq.value;
          shadow_dirty[s] = 1'b1;
        end else begin
          insert_entry(rq.key, rq.value, 1'b1);
        end
        push_resp(RESP_DONE, rq.key, 64'd0);
      end
      REQ_FILL: begin
        if (!rq.found) begin
          push_resp(RESP_NOTFOUND, rq.key, 64'd0);
        end else begin
          s = lookup_slot(rq.key);
          if (s >= 0) begin
            push_resp(RESP_READ, rq.key, shadow_val[s]);
          end else begin
            insert_entry(rq.key, rq.value, 1'b0);
            push_resp(RESP_READ, rq.key, rq.value);
          end
        end
      end
      default: begin
        cap = slots_in_use();
        for (int unsigned i = 0; i < shadow_count && i < cap; i++) begin
          q = (shadow_oldest + i) % cap;
          if (shadow_dirty[q]) begin
            push_resp(RESP_BWRITE, shadow_key[q], shadow_val[q]);
            shadow_dirty[q] = 1'b0;
          end
        end
        empty_shadow();
        push_resp(RESP_DONE, 64'd0, 64'd0);
      end
    endcase
    r = expected_resps.pop_back();
    r.last = 1'b1;
    expected_resps.push_back(r);
  endfunction

  function automatic void queue_req(req_type_t t, logic [63:0] key, logic [63:0] value,
                                    logic found);
    cache_req_t rq;
    rq.rtype = t;
    rq.key = key;
    rq.value = value;
    rq.found = found;
    pending_reqs.push_back(rq);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 64'd0;
    if (r < 10) return '1;
    return rand64();
  endfunction

  // Mostly well-formed traffic on a small key pool so hits and evictions happen
  function automatic void queue_random(int n);
    int unsigned r;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = key_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 30) begin
        queue_req(REQ_GET, k, rand64(), 1'($urandom_range(1)));
        queue_req(REQ_FILL, k, rand_value(), $urandom_range(99) < 80);
        i++;
      end else if (r < 55) begin
        queue_req(REQ_SET, k, rand_value(), 1'($urandom_range(1)));
      end else if (r < 73) begin
        queue_req(REQ_GET, k, rand64(), 1'($urandom_range(1)));
      end else if (r < 85) begin
        queue_req(REQ_FILL, k, rand_value(), 1'($urandom_range(1)));
      end else if (r < 91) begin
        queue_req(REQ_FLUSH, rand64(), rand64(), 1'($urandom_range(1)));
      end else begin
        queue_req(req_type_t'($urandom_range(3)), rand64(), rand_value(),
                  1'($urandom_range(1)));
      end
    end
  endfunction

  // Feed requests; predict on the accepting edge, hold while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_cache(cur_req);
        accepted_count++;
      end
      if (!(start && busy)) begin
        if (!feed_hold && pending_reqs.size() > 0 &&
            ((accepted_count >= 150 && accepted_count < 240) || $urandom_range(99) >= 12)) begin
          cur_req = pending_reqs.pop_front();
          req_type <= cur_req.rtype;
          req_key <= cur_req.key;
          req_value <= cur_req.value;
          fill_found <= cur_req.found;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Compare each response transaction with the oldest expectation
  always @(posedge clk) begin
    cache_resp_t e;
    if (!rst && resp_valid) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected response kind=%0d key=%h", resp_kind, resp_key);
        error_count++;
      end else begin
        e = expected_resps.pop_front();
        if (resp_kind !== e.kind) begin
          $error("resp_kind expected %0d actual %0d", e.kind, resp_kind);
          error_count++;
        end
        if (resp_key !== e.key) begin
          $error("resp_key expected %h actual %h", e.key, resp_key);
          error_count++;
        end
        if (resp_value !== e.value) begin
          $error("resp_value expected %h actual %h", e.value, resp_value);
          error_count++;
        end
        if (resp_last !== e.last) begin
          $error("resp_last expected %0d actual %0d", e.last, resp_last);
          error_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fifo_write_back_cache verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || busy || expected_resps.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // Two-phase register write; shadow state follows at the write edge
  task automatic write_capacity(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE_CAPACITY;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shadow_capacity = value[4:0];
    empty_shadow();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [31:0] cap_list [6];
    cap_list = '{32'd3, 32'd1, 32'd0, 32'd31, 32'd16, 32'd7};
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_GET;
    req_key = '0;
    req_value = '0;
    fill_found = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_ACTIVE_CAPACITY;
    pwdata = '0;
    feed_hold = 1'b1;
    accepted_count = 0;
    error_count = 0;
    cycle_count = 0;
    shadow_capacity = 5'd16;
    empty_shadow();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand64();
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, hit and miss, fills, update, filling every slot, big flush
    queue_req(REQ_GET, 64'd0, '1, 1'b1);
    queue_req(REQ_FLUSH, '1, '1, 1'b1);
    queue_req(REQ_SET, 64'd0, '1, 1'b0);
    queue_req(REQ_GET, 64'd0, 64'd0, 1'b0);
    queue_req(REQ_SET, 64'd0, 64'h0123_4567_89ab_cdef, 1'b1);
    queue_req(REQ_GET, '1, 64'd0, 1'b0);
    queue_req(REQ_FILL, '1, '1, 1'b0);
    queue_req(REQ_FILL, '1, 64'd0, 1'b1);
    queue_req(REQ_FILL, 64'd0, 64'h5555, 1'b1);
    queue_req(REQ_GET, '1, 64'd0, 1'b0);
    for (int i = 0; i < 14; i++) queue_req(REQ_SET, rand64(), rand_value(), 1'b0);
    queue_req(REQ_FLUSH, 64'd0, 64'd0, 1'b0);
    feed_hold = 1'b0;
    wait_drained();

    // Random traffic under several capacities, drained before each write
    foreach (cap_list[p]) begin
      feed_hold = 1'b1;
      write_capacity(cap_list[p]);
      queue_random(66);
      feed_hold = 1'b0;
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_resps.size() == 0) begin
      $display("fifo_write_back_cache verification clean");
    end else begin
      $display("fifo_write_back_cache verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/fwbc_pkg.sv
rtl/core/fifo_write_back_cache.sv
rtl/core/fwbc_checker.sv
tb/tb_fifo_write_back_cache.sv
